### hdl/auto_gain_exposure_step_unit_defines.svh
// ----------------------------------------------------------------------------
// auto_gain_exposure_step_unit_defines
// Assertion macros for the gain and exposure step unit.
// ----------------------------------------------------------------------------
`ifndef AUTO_GAIN_EXPOSURE_STEP_UNIT_DEFINES_SVH
`define AUTO_GAIN_EXPOSURE_STEP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define AGES_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ages check failed");
`define AGES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ages check failed");
`else
`define AGES_ASSERT_IMPLY(lbl, ante, cons)
`define AGES_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/ages_pkg.sv
// ----------------------------------------------------------------------------
// ages_pkg
// Types and constants shared by the gain and exposure step pipeline.
// ----------------------------------------------------------------------------
package ages_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [7:0]  LEVEL_SETPOINT = 8'd127;
  localparam logic [7:0]  NEAR_BAND     = 8'd31;
  localparam logic [16:0] ONE_Q16       = 17'h10000;
  // mag * 40 > 127 * 65536  <=>  mag > 208076
  localparam logic [23:0] DEAD_MAG_MAX  = 24'd208076;
  localparam logic [23:0] ROUND_BIAS    = 24'd63;
  // floor(2^31 / 127)
  localparam logic [24:0] RECIP_K       = 25'd16909320;
  localparam logic [41:0] SCALE_ROUND   = 42'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED    = 3'd0,
    CFG_GAIN_MIN = 3'd1,
    CFG_GAIN_MAX = 3'd2,
    CFG_EXPO_MIN = 3'd3,
    CFG_EXPO_MAX = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CHG_NONE = 2'd0,
    CHG_EXPO = 2'd1,
    CHG_GAIN = 2'd2
  } chg_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] gain_min;
    logic [15:0] gain_max;
    logic [23:0] exposure_min;
    logic [23:0] exposure_max;
  } cfg_t;

  typedef struct packed {
    logic        up;
    logic [23:0] mag;
    logic [15:0] gain;
    logic [23:0] expo;
  } damp_t;

  typedef struct packed {
    chg_t        chg;
    logic        fpos;
    logic [17:0] fmag;
    logic [23:0] x;
    logic [15:0] gain;
    logic [23:0] expo;
  } factor_t;

  typedef struct packed {
    chg_t        chg;
    logic [15:0] gain;
    logic [23:0] expo;
  } result_t;

endpackage

### hdl/ages_damp.sv
// ----------------------------------------------------------------------------
// ages_damp
// Error distance, effective speed and damped error magnitude (two stages).
// ----------------------------------------------------------------------------
module ages_damp import ages_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [7:0]  signal_level,
  input  logic [15:0] gain_now,
  input  logic [23:0] exposure_now,
  input  cfg_t        cfg,
  output logic        out_valid,
  output damp_t       out
);

  logic        up_c;
  logic [7:0]  dist_c;
  logic        near_c;
  logic [31:0] sq_full;

  logic        v1;
  logic        up1;
  logic        near1;
  logic [7:0]  dist1;
  logic [15:0] sq1;
  logic [15:0] gain1;
  logic [23:0] expo1;

  logic [15:0] speff;
  logic [16:0] damp;
  logic [24:0] mag_full;

  always_comb begin
    up_c    = signal_level < LEVEL_SETPOINT;
    dist_c  = up_c ? (LEVEL_SETPOINT - signal_level) : (signal_level - LEVEL_SETPOINT);
    near_c  = (signal_level == 8'd0) || (signal_level == 8'hFF) || (dist_c <= NEAR_BAND);
    sq_full = cfg.speed * cfg.speed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up1   <= up_c;
      near1 <= near_c;
      dist1 <= dist_c;
      sq1   <= sq_full[31:16];
      gain1 <= gain_now;
      expo1 <= exposure_now;
    end
  end

  always_comb begin
    speff    = near1 ? sq1 : cfg.speed;
    damp     = ONE_Q16 - {1'b0, speff};
    mag_full = damp * dist1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.up   <= up1;
      out.mag  <= mag_full[23:0];
      out.gain <= gain1;
      out.expo <= expo1;
    end
  end

endmodule

### hdl/ages_factor.sv
// ----------------------------------------------------------------------------
// ages_factor
// Dead band, rounded division by 127 and gain factor with branch choice.
// ----------------------------------------------------------------------------
module ages_factor import ages_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  damp_t   in,
  input  cfg_t    cfg,
  output logic    out_valid,
  output factor_t out
);

  logic [23:0] m_c;

  logic        v3;
  logic        up3;
  logic        live3;
  logic [23:0] m3;
  logic [48:0] prod3;
  logic [15:0] gain3;
  logic [23:0] expo3;

  logic [16:0] q0;
  logic [23:0] q127;
  logic [24:0] rem;
  logic [16:0] q;
  logic        sel_expo;
  logic        fpos_c;
  logic [17:0] fmag_c;
  chg_t        chg_c;

  assign m_c = in.mag + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up3   <= in.up;
      live3 <= in.mag > DEAD_MAG_MAX;
      m3    <= m_c;
      prod3 <= m_c * RECIP_K;
      gain3 <= in.gain;
      expo3 <= in.expo;
    end
  end

  always_comb begin
    q0   = prod3[47:31];
    q127 = {q0, 7'd0} - {7'd0, q0};
    rem  = {1'b0, m3} - {1'b0, q127};
    q    = (rem >= 25'd127) ? (q0 + 17'd1) : q0;
    if (up3) begin
      fpos_c = 1'b1;
      fmag_c = {1'b0, ONE_Q16} + {1'b0, q};
    end else begin
      fpos_c = q < ONE_Q16;
      fmag_c = {1'b0, ONE_Q16} - {1'b0, q};
    end
    sel_expo = up3 ? (expo3 < cfg.exposure_max) : !(gain3 > cfg.gain_min);
    if (!live3) begin
      chg_c = CHG_NONE;
    end else if (sel_expo) begin
      chg_c = CHG_EXPO;
    end else begin
      chg_c = CHG_GAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.chg  <= chg_c;
      out.fpos <= fpos_c;
      out.fmag <= fmag_c;
      out.x    <= sel_expo ? expo3 : {8'd0, gain3};
      out.gain <= gain3;
      out.expo <= expo3;
    end
  end

endmodule

### hdl/ages_scale.sv
// ----------------------------------------------------------------------------
// ages_scale
// Scale the chosen setting by the factor, round, clamp and register the beat.
// ----------------------------------------------------------------------------
module ages_scale import ages_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  factor_t in,
  input  cfg_t    cfg,
  output logic    out_valid,
  output result_t out
);

  logic        v5;
  logic [41:0] prod5;
  logic        fpos5;
  chg_t        chg5;
  logic [15:0] gain5;
  logic [23:0] expo5;

  logic [42:0] sum;
  logic [26:0] raw;
  logic [26:0] lo;
  logic [26:0] hi;
  logic [26:0] clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod5 <= in.x * in.fmag;
      fpos5 <= in.fpos;
      chg5  <= in.chg;
      gain5 <= in.gain;
      expo5 <= in.expo;
    end
  end

  always_comb begin
    sum = {1'b0, prod5} + {1'b0, SCALE_ROUND};
    raw = fpos5 ? sum[42:16] : 27'd0;
    if (chg5 == CHG_EXPO) begin
      lo = {3'd0, cfg.exposure_min};
      hi = {3'd0, cfg.exposure_max};
    end else begin
      lo = {11'd0, cfg.gain_min};
      hi = {11'd0, cfg.gain_max};
    end
    if (raw < lo) begin
      clamped = lo;
    end else if (raw > hi) begin
      clamped = hi;
    end else begin
      clamped = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.chg  <= chg5;
      out.gain <= (chg5 == CHG_GAIN) ? clamped[15:0] : gain5;
      out.expo <= (chg5 == CHG_EXPO) ? clamped[23:0] : expo5;
    end
  end

endmodule

### hdl/auto_gain_exposure_step_unit.sv
// ----------------------------------------------------------------------------
// auto_gain_exposure_step_unit
// One automatic gain and exposure control step per beat, six-stage pipeline.
//
//   channel  direction  handshake          payload
//   s_*      in         tvalid / tready    signal level, gain, exposure
//   m_*      out        tvalid / tready    next gain, next exposure, change code
//   cfg_*    in         valid / ready      register index, write data
//
// One beat enters per cycle while the output is not stalled.
// Every stage advances together when the output register is empty or taken.
// A stalled output holds all stages, so nothing is dropped or repeated.
// rst is synchronous and loads the register reset values; cfg_ready is high.
// ----------------------------------------------------------------------------
`include "auto_gain_exposure_step_unit_defines.svh"

module auto_gain_exposure_step_unit import ages_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // signal_level, gain_now, exposure_now
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // gain_next, exposure_next, changed_setting
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  logic    en;
  logic    damp_valid;
  damp_t   damp;
  logic    factor_valid;
  factor_t factor;
  result_t result;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed        <= 16'd64881;
      cfg.gain_min     <= 16'd4096;
      cfg.gain_max     <= 16'd43688;
      cfg.exposure_min <= 24'd9472;
      cfg.exposure_max <= 24'd1238784;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPEED:    cfg.speed        <= cfg_data[15:0];
        CFG_GAIN_MIN: cfg.gain_min     <= cfg_data[15:0];
        CFG_GAIN_MAX: cfg.gain_max     <= cfg_data[15:0];
        CFG_EXPO_MIN: cfg.exposure_min <= cfg_data;
        CFG_EXPO_MAX: cfg.exposure_max <= cfg_data;
        default: ;
      endcase
    end
  end

  ages_damp u_damp (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_tvalid),
    .signal_level (s_tdata[7:0]),
    .gain_now     (s_tdata[23:8]),
    .exposure_now (s_tdata[47:24]),
    .cfg          (cfg),
    .out_valid    (damp_valid),
    .out          (damp)
  );

  ages_factor u_factor (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (damp_valid),
    .in        (damp),
    .cfg       (cfg),
    .out_valid (factor_valid),
    .out       (factor)
  );

  ages_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (factor_valid),
    .in        (factor),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out       (result)
  );

  assign m_tdata = {6'd0, result.chg, result.expo, result.gain};

  `AGES_ASSERT_IMPLY(a_code_legal, m_tvalid, m_tdata[41:40] != 2'd3)
  `AGES_ASSERT_IMPLY(a_expo_clamped,
    m_tvalid && (result.chg == CHG_EXPO) && (cfg.exposure_min <= cfg.exposure_max),
    (result.expo >= cfg.exposure_min) && (result.expo <= cfg.exposure_max))
  `AGES_ASSERT_IMPLY(a_gain_clamped,
    m_tvalid && (result.chg == CHG_GAIN) && (cfg.gain_min <= cfg.gain_max),
    (result.gain >= cfg.gain_min) && (result.gain <= cfg.gain_max))
  `AGES_ASSERT_NEXT(a_speed_write,
    !rst && cfg_valid && (cfg_index == CFG_SPEED),
    cfg.speed == $past(cfg_data[15:0]))

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the automatic gain and exposure step unit.
//
// Measurement beats (signal level, gain, exposure) stream into s_* from a
// queue. Each accepted beat is run through a bit-exact fixed-point step model
// kept here, and the adjusted gain, exposure and change code are queued. Beats
// leaving m_* are compared field by field, in order, with that queue. The run
// walks through several register settings, among them the reset values, zero
// and full-scale speed, wide, tight and crossed limits, and an unused register
// index. Phases differ in sender gaps and receiver stalls. Registers are only
// written while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import ages_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned DEAD_BAND_DIV  = 40;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam cfg_t CFG_RESET = '{
    speed:        16'd64881,
    gain_min:     16'd4096,
    gain_max:     16'd43688,
    exposure_min: 24'd9472,
    exposure_max: 24'd1238784
  };

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;   // signal_level, gain_now, exposure_now
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;        // gain_next, exposure_next, changed_setting
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  cfg_t               model_cfg = CFG_RESET;
  logic [InDataW-1:0] measure_q[$];
  result_t            adjusted_q[$];
  reg_write_t         reg_write_q[$];
  reg_write_t         reg_cur;
  result_t            want;
  result_t            got;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_meas_sent = 0;
  int unsigned n_meas_taken = 0;
  int unsigned n_reg_sent = 0;
  int unsigned n_reg_taken = 0;
  int unsigned n_adjust_seen = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_cycles = 0;

  auto_gain_exposure_step_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned scale_q16(longint unsigned x, longint fac);
    if (fac <= 0) begin
      return 0;
    end
    return (x * longint'(fac) + 64'd32768) >> 16;
  endfunction

  function automatic longint unsigned clamp_lim(longint unsigned v, longint unsigned lo,
                                                longint unsigned hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic result_t adjust_settings(logic [7:0] lvl, logic [15:0] gain,
                                              logic [23:0] expo);
    result_t         r;
    logic            up;
    longint unsigned lvl_dist;
    longint unsigned eff_speed;
    longint unsigned damping;
    longint unsigned err_mag;
    longint unsigned band_lim;
    longint unsigned step_q;
    longint          fac;
    r.gain = gain;
    r.expo = expo;
    r.chg  = CHG_NONE;
    up   = lvl < LEVEL_SETPOINT;
    lvl_dist = up ? 64'(LEVEL_SETPOINT - lvl) : 64'(lvl - LEVEL_SETPOINT);
    eff_speed = 64'(model_cfg.speed);
    if (lvl == 8'd0 || lvl == 8'd255 || lvl_dist <= 64'(NEAR_BAND)) begin
      eff_speed = (eff_speed * eff_speed) >> 16;
    end
    damping  = 64'(ONE_Q16) - eff_speed;
    err_mag  = damping * lvl_dist;
    band_lim = 64'(LEVEL_SETPOINT) * 64'(ONE_Q16);
    if (err_mag * 64'(DEAD_BAND_DIV) > band_lim) begin
      step_q = (err_mag * 64'd2 + 64'(LEVEL_SETPOINT)) / (64'd2 * 64'(LEVEL_SETPOINT));
      fac = up ? longint'(64'(ONE_Q16) + step_q) : longint'(64'(ONE_Q16)) - longint'(step_q);
      if ((up && expo < model_cfg.exposure_max) || (!up && !(gain > model_cfg.gain_min))) begin
        r.expo = 24'(clamp_lim(scale_q16(64'(expo), fac), 64'(model_cfg.exposure_min),
                               64'(model_cfg.exposure_max)));
        r.chg  = CHG_EXPO;
      end else begin
        r.gain = 16'(clamp_lim(scale_q16(64'(gain), fac), 64'(model_cfg.gain_min),
                               64'(model_cfg.gain_max)));
        r.chg  = CHG_GAIN;
      end
    end
    return r;
  endfunction

  function automatic logic [InDataW-1:0] random_measure();
    logic [7:0]  lvl;
    logic [15:0] gain;
    logic [23:0] expo;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(8))
        0:       lvl = 8'd0;
        1:       lvl = 8'd1;
        2:       lvl = 8'd95;
        3:       lvl = 8'd96;
        4:       lvl = 8'd158;
        5:       lvl = 8'd159;
        6:       lvl = 8'd254;
        7:       lvl = 8'd255;
        default: lvl = 8'd127;
      endcase
    end else begin
      lvl = 8'($urandom_range(255));
    end
    case ($urandom_range(4))
      0:       gain = model_cfg.gain_min;
      1:       gain = model_cfg.gain_min + 16'($urandom_range(6)) - 16'd3;
      2:       gain = model_cfg.gain_max + 16'($urandom_range(6)) - 16'd3;
      default: gain = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0:       expo = model_cfg.exposure_max;
      1:       expo = model_cfg.exposure_max + 24'($urandom_range(6)) - 24'd3;
      2:       expo = model_cfg.exposure_min + 24'($urandom_range(6)) - 24'd3;
      default: expo = 24'($urandom);
    endcase
    return {expo, gain, lvl};
  endfunction

  // measurement driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        adjusted_q.push_back(adjust_settings(s_tdata[7:0], s_tdata[23:8], s_tdata[47:24]));
        n_meas_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (measure_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= measure_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      model_cfg = CFG_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED:    model_cfg.speed = cfg_data[15:0];
          CFG_GAIN_MIN: model_cfg.gain_min = cfg_data[15:0];
          CFG_GAIN_MAX: model_cfg.gain_max = cfg_data[15:0];
          CFG_EXPO_MIN: model_cfg.exposure_min = cfg_data;
          CFG_EXPO_MAX: model_cfg.exposure_max = cfg_data;
          default: ;
        endcase
        n_reg_taken++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_write_q.size() > 0) begin
          reg_cur = reg_write_q.pop_front();
          cfg_index <= reg_cur.idx;
          cfg_data  <= reg_cur.data;
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.gain = m_tdata[15:0];
        got.expo = m_tdata[39:16];
        got.chg  = chg_t'(m_tdata[41:40]);
        if (adjusted_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("unexpected beat %0d: gain %h expo %h chg %0d",
                     n_adjust_seen, got.gain, got.expo, got.chg);
          end
        end else begin
          want = adjusted_q.pop_front();
          if (got.gain !== want.gain || got.expo !== want.expo || got.chg !== want.chg) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
              $display("beat %0d: expected gain %h expo %h chg %0d, got gain %h expo %h chg %0d",
                       n_adjust_seen, want.gain, want.expo, want.chg,
                       got.gain, got.expo, got.chg);
            end
          end
        end
        n_adjust_seen++;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_measure(logic [7:0] lvl, logic [15:0] gain, logic [23:0] expo);
    measure_q.push_back({expo, gain, lvl});
    n_meas_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    reg_write_q.push_back('{idx: idx, data: val});
    n_reg_sent++;
  endtask

  task automatic settle_regs();
    while (n_reg_taken != n_reg_sent) begin
      @(posedge clk);
    end
  endtask

  task automatic drain();
    while (n_meas_taken != n_meas_sent || adjusted_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_random(int unsigned count, int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      measure_q.push_back(random_measure());
      n_meas_sent++;
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_random(120, 0, 0);

    write_reg(CFG_SPEED, 24'd0);
    settle_regs();
    push_measure(8'd127, 16'h2000, 24'h010000);
    push_measure(8'd124, 16'h2000, 24'h010000);
    push_measure(8'd123, 16'h2000, 24'h010000);
    push_measure(8'd0,   16'h2000, 24'h010000);
    push_measure(8'd255, 16'h2000, 24'h010000);
    push_measure(8'd254, 16'h2000, 24'h010000);
    push_measure(8'd253, 16'h2000, 24'h010000);
    push_measure(8'd96,  16'h2000, 24'h010000);
    push_measure(8'd95,  16'h2000, 24'h010000);
    push_measure(8'd158, 16'h2000, 24'h010000);
    push_measure(8'd159, 16'h2000, 24'h010000);
    push_measure(8'd0,   16'h2000, 24'd1238784);
    push_measure(8'd0,   16'hFFFF, 24'hFFFFFF);
    push_measure(8'd200, 16'd4096, 24'h010000);
    push_measure(8'd255, 16'h0000, 24'h000000);
    push_measure(8'd10,  16'hFFFF, 24'h000000);
    push_measure(8'd200, 16'hFFFF, 24'hFFFFFF);
    push_measure(8'd60,  16'h5555, 24'hAAAAAA);
    push_measure(8'd190, 16'hAAAA, 24'h555555);
    drain();
    run_random(200, 0, 0);

    write_reg(CFG_SPEED, 24'd16384);
    write_reg(CFG_GAIN_MIN, 24'd0);
    write_reg(CFG_GAIN_MAX, 24'd65535);
    write_reg(CFG_EXPO_MIN, 24'd0);
    write_reg(CFG_EXPO_MAX, 24'hFFFFFF);
    settle_regs();
    run_random(220, 65, 0);

    write_reg(CFG_SPEED, 24'd65535);
    write_reg(CFG_GAIN_MIN, 24'd2000);
    write_reg(CFG_GAIN_MAX, 24'd50000);
    write_reg(CFG_EXPO_MIN, 24'h000100);
    write_reg(CFG_EXPO_MAX, 24'h200000);
    settle_regs();
    run_random(120, 0, 65);

    // crossed limits
    write_reg(CFG_SPEED, 24'd40000);
    write_reg(CFG_GAIN_MIN, 24'd50000);
    write_reg(CFG_GAIN_MAX, 24'd10000);
    write_reg(CFG_EXPO_MIN, 24'hF00000);
    write_reg(CFG_EXPO_MAX, 24'h001000);
    settle_regs();
    run_random(220, 13, 13);

    write_reg(CFG_SPEED, 24'd1);
    write_reg(CFG_GAIN_MIN, 24'd65535);
    write_reg(CFG_GAIN_MAX, 24'd0);
    write_reg(CFG_EXPO_MIN, 24'hFFFFFF);
    write_reg(CFG_EXPO_MAX, 24'd0);
    write_reg(CFG_UNUSED_IDX, 24'h5A5A5A);
    settle_regs();
    run_random(200, 0, 65);

    write_reg(CFG_SPEED, 24'd8000);
    write_reg(CFG_GAIN_MIN, 24'd4096);
    write_reg(CFG_GAIN_MAX, 24'd43688);
    write_reg(CFG_EXPO_MIN, 24'd9472);
    write_reg(CFG_EXPO_MAX, 24'd1238784);
    settle_regs();
    // hold the sender until the pipeline is empty, then resume
    run_random(120, 0, 0);
    run_random(120, 13, 13);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
